@@ rtl/lens_distortion_coordinate_map_core_macros.svh @@
// assertion helpers for the coordinate map core
`ifndef LENS_DISTORTION_COORDINATE_MAP_CORE_MACROS_SVH
`define LENS_DISTORTION_COORDINATE_MAP_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LDCM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ldcm check failed");

// next-cycle implication, checked outside reset
`define LDCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ldcm check failed");

`endif

@@ rtl/ldcm_pkg.sv @@
package ldcm_pkg;

    localparam int COL_W       = 12;
    localparam int DIM_W       = 14;
    localparam int MAX_DIM_DEF = 4096;
    localparam int XS_W        = 45;
    localparam int NUM_W       = 61;
    localparam int DIV_STAGES  = NUM_W;
    localparam int FR_N        = 3 + DIV_STAGES;
    localparam int PT_N        = 24;

    typedef logic signed [62:0] sq_t;

    localparam logic [62:0]        LIM_M  = {1'b0, {62{1'b1}}};
    localparam logic signed [63:0] LIM64  = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam sq_t                ONE_Q24 = 63'sd16777216;

    typedef enum logic [2:0] {
        CFG_FOCAL   = 3'd0,
        CFG_CENTRE  = 3'd1,
        CFG_K1      = 3'd2,
        CFG_K2      = 3'd3,
        CFG_K3      = 3'd4,
        CFG_TANG    = 3'd5,
        CFG_SCALE   = 3'd6,
        CFG_SIZE    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0]      rem;
        logic [NUM_W-1:0] num;
        logic             neg;
        logic             nzero;
    } div_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        logic [XS_W-1:0]  xs;
        logic [XS_W-1:0]  ys;
        div_t             dx;
        div_t             dy;
    } fr_t;

    typedef struct packed {
        logic        neg;
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
    } pp_t;

    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [63:0] m;
    } sum_t;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [COL_W-1:0]   row;
        sq_t                xn;
        sq_t                yn;
        sq_t                xx;
        sq_t                yy;
        sq_t                xy;
        sq_t                r2;
        sq_t                xy2;
        sq_t                xx2;
        sq_t                yy2;
        sq_t                ax;
        sq_t                ay;
        sq_t                r4;
        sq_t                k1r2;
        sq_t                t1;
        sq_t                t2;
        sq_t                t3;
        sq_t                t4;
        sq_t                tx;
        sq_t                ty;
        sq_t                r6;
        sq_t                k2r4;
        sq_t                k3r6;
        sq_t                radial;
        sq_t                rx;
        sq_t                ry;
        sq_t                dxn;
        sq_t                dyn;
        sq_t                ux;
        sq_t                uy;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        pp_t [5:0]          pp;
        sum_t [5:0]         sm;
    } pt_t;

    function automatic sq_t sx32(input logic [31:0] v);
        return sq_t'($signed(v));
    endfunction

    function automatic sq_t ux32(input logic [31:0] v);
        return $signed({31'b0, v});
    endfunction

    // partial products of the magnitudes, at most 32x32 each
    function automatic pp_t qm_pp(input sq_t a, input sq_t b);
        logic [62:0] ua;
        logic [62:0] ub;
        pp_t         r;
        ua    = a[62] ? 63'(-a) : a;
        ub    = b[62] ? 63'(-b) : b;
        r.neg = a[62] ^ b[62];
        r.p00 = 64'(ua[31:0]) * 64'(ub[31:0]);
        r.p01 = 64'(ua[31:0]) * 64'(ub[62:32]);
        r.p10 = 64'(ua[62:32]) * 64'(ub[31:0]);
        r.p11 = 64'(ua[62:32]) * 64'(ub[62:32]);
        return r;
    endfunction

    function automatic sum_t qm_sum(input pp_t p);
        logic [33:0] mid;
        logic [63:0] lo;
        logic [63:0] hi;
        sum_t        r;
        mid   = 34'(p.p00[63:32]) + 34'(p.p01[31:0]) + 34'(p.p10[31:0]);
        lo    = {mid[31:0], p.p00[31:0]};
        hi    = p.p11 + 64'(p.p01[63:32]) + 64'(p.p10[63:32]) + 64'(mid[33:32]);
        r.neg = p.neg;
        r.ovf = |hi[63:24];
        r.m   = {hi[23:0], lo[63:24]};
        return r;
    endfunction

    function automatic sq_t qm_sat(input sum_t s);
        logic [62:0] v;
        v = (s.ovf || (s.m > {1'b0, LIM_M})) ? LIM_M : s.m[62:0];
        return s.neg ? sq_t'(-$signed(v)) : $signed(v);
    endfunction

    function automatic sq_t sadd(input sq_t a, input sq_t b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        if (s > LIM64) begin
            return $signed(LIM_M);
        end
        if (s < -LIM64) begin
            return sq_t'(-$signed(LIM_M));
        end
        return s[62:0];
    endfunction

    function automatic logic [31:0] to_q16(input sq_t v);
        if (v > 63'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -63'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // offset from the centre in Q.25, magnitude shifted up for the divider
    function automatic div_t norm_init(input logic [XS_W-1:0] xs, input logic [31:0] c);
        logic signed [46:0] d;
        logic [46:0]        dm;
        div_t               r;
        d       = $signed({2'b00, xs}) - $signed({{6{c[31]}}, c, 9'b0});
        dm      = d[46] ? 47'(-d) : 47'(d);
        r.rem   = '0;
        r.num   = {dm[45:0], 15'b0};
        r.neg   = d[46];
        r.nzero = (dm == '0);
        return r;
    endfunction

    // one restoring division step
    function automatic div_t div_step(input div_t d, input logic [31:0] f);
        logic [32:0] t;
        logic        qb;
        div_t        r;
        r = d;
        t = {d.rem, d.num[NUM_W-1]};
        if (t >= {1'b0, f}) begin
            r.rem = 32'(t - {1'b0, f});
            qb    = 1'b1;
        end
        else begin
            r.rem = t[31:0];
            qb    = 1'b0;
        end
        r.num = {d.num[NUM_W-2:0], qb};
        return r;
    endfunction

    function automatic sq_t norm_fin(input div_t d, input logic [31:0] f);
        sq_t v;
        if (d.nzero) begin
            v = '0;
        end
        else if (f == '0) begin
            v = $signed(LIM_M);
        end
        else begin
            v = $signed({2'b00, d.num});
        end
        return d.neg ? sq_t'(-v) : v;
    endfunction

endpackage

@@ rtl/lens_distortion_coordinate_map_core.sv @@
// channel   | dir | payload (low bit first)                     | handshake
// s_        | in  | pixel_col, pixel_row                        | tvalid/tready
// m_        | out | dest_col, dest_row, source_x, source_y      | tvalid/tready
// cfg_      | in  | register index, data                        | write enable only
// one word enters per cycle while no stall at the output holds the pipeline
// the depth is set by the 61-step restoring divider for normalisation
// words outside the output size are dropped in the second stage and leave a bubble
// a stall at the output freezes every stage at once, so nothing is lost or repeated
// reset clears the valid bits and loads the registers with their default values
`include "lens_distortion_coordinate_map_core_macros.svh"

module lens_distortion_coordinate_map_core #(
    parameter int MAX_DIM = ldcm_pkg::MAX_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_col, pixel_row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // dest_col, dest_row, source_x, source_y
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_data
);

    localparam int FR_N = ldcm_pkg::FR_N;
    localparam int PT_N = ldcm_pkg::PT_N;

    logic [63:0] focal_reg;
    logic [63:0] centre_reg;
    logic [31:0] k1_reg;
    logic [31:0] k2_reg;
    logic [31:0] k3_reg;
    logic [63:0] tang_reg;
    logic [63:0] scale_reg;
    logic [25:0] size_reg;

    logic [ldcm_pkg::DIM_W-1:0] w_clamp;
    logic [ldcm_pkg::DIM_W-1:0] h_clamp;
    logic                       adv;

    ldcm_pkg::fr_t fr_reg  [FR_N];
    ldcm_pkg::fr_t fr_next [FR_N];
    logic [FR_N-1:0] fv_reg;
    logic [FR_N-1:0] fv_next;

    ldcm_pkg::pt_t pt_reg  [PT_N];
    ldcm_pkg::pt_t pt_next [PT_N];
    logic [PT_N-1:0] pv_reg;
    logic [PT_N-1:0] pv_next;

    ldcm_pkg::sq_t k1;
    ldcm_pkg::sq_t k2;
    ldcm_pkg::sq_t k3;
    ldcm_pkg::sq_t p1;
    ldcm_pkg::sq_t p2;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg  <= 64'h0001_0000_0001_0000;
            centre_reg <= '0;
            k1_reg     <= '0;
            k2_reg     <= '0;
            k3_reg     <= '0;
            tang_reg   <= '0;
            scale_reg  <= 64'h0100_0000_0100_0000;
            size_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (ldcm_pkg::cfg_idx_t'(cfg_addr))
                ldcm_pkg::CFG_FOCAL:  focal_reg  <= cfg_data;
                ldcm_pkg::CFG_CENTRE: centre_reg <= cfg_data;
                ldcm_pkg::CFG_K1:     k1_reg     <= cfg_data[31:0];
                ldcm_pkg::CFG_K2:     k2_reg     <= cfg_data[31:0];
                ldcm_pkg::CFG_K3:     k3_reg     <= cfg_data[31:0];
                ldcm_pkg::CFG_TANG:   tang_reg   <= cfg_data;
                ldcm_pkg::CFG_SCALE:  scale_reg  <= cfg_data;
                ldcm_pkg::CFG_SIZE:   size_reg   <= cfg_data[25:0];
                default:              size_reg   <= size_reg;
            endcase
        end
    end

    always_comb
    begin
        w_clamp = (14'(size_reg[12:0]) > 14'(MAX_DIM)) ? 14'(MAX_DIM) : 14'(size_reg[12:0]);
        h_clamp = (14'(size_reg[25:13]) > 14'(MAX_DIM)) ? 14'(MAX_DIM) : 14'(size_reg[25:13]);
        k1 = ldcm_pkg::sx32(k1_reg);
        k2 = ldcm_pkg::sx32(k2_reg);
        k3 = ldcm_pkg::sx32(k3_reg);
        p1 = ldcm_pkg::sx32(tang_reg[63:32]);
        p2 = ldcm_pkg::sx32(tang_reg[31:0]);
    end

    assign adv      = !pv_reg[PT_N-1] || m_tready;
    assign s_tready = adv;

    // front end: frame check, scaling, normalising divider
    always_comb
    begin
        fr_next[0]     = fr_reg[0];
        fr_next[0].col = s_tdata[11:0];
        fr_next[0].row = s_tdata[23:12];
        fv_next[0]     = s_tvalid;

        fr_next[1]    = fr_reg[0];
        fr_next[1].xs = ldcm_pkg::XS_W'({fr_reg[0].col, 1'b1}) * ldcm_pkg::XS_W'(scale_reg[63:32]);
        fr_next[1].ys = ldcm_pkg::XS_W'({fr_reg[0].row, 1'b1}) * ldcm_pkg::XS_W'(scale_reg[31:0]);
        fv_next[1]    = fv_reg[0] && (14'(fr_reg[0].col) < w_clamp)
                        && (14'(fr_reg[0].row) < h_clamp);

        fr_next[2]    = fr_reg[1];
        fr_next[2].dx = ldcm_pkg::norm_init(fr_reg[1].xs, centre_reg[63:32]);
        fr_next[2].dy = ldcm_pkg::norm_init(fr_reg[1].ys, centre_reg[31:0]);
        fv_next[2]    = fv_reg[1];

        for (int k = 3; k < FR_N; k++)
        begin
            fr_next[k]    = fr_reg[k-1];
            fr_next[k].dx = ldcm_pkg::div_step(fr_reg[k-1].dx, focal_reg[63:32]);
            fr_next[k].dy = ldcm_pkg::div_step(fr_reg[k-1].dy, focal_reg[31:0]);
            fv_next[k]    = fv_reg[k-1];
        end
    end

    // back end: distortion polynomial, three stages per product
    always_comb
    begin
        for (int k = 1; k < PT_N; k++)
        begin
            pt_next[k] = pt_reg[k-1];
            pv_next[k] = pv_reg[k-1];
        end
        pt_next[0]     = pt_reg[0];
        pt_next[0].col = fr_reg[FR_N-1].col;
        pt_next[0].row = fr_reg[FR_N-1].row;
        pt_next[0].xn  = ldcm_pkg::norm_fin(fr_reg[FR_N-1].dx, focal_reg[63:32]);
        pt_next[0].yn  = ldcm_pkg::norm_fin(fr_reg[FR_N-1].dy, focal_reg[31:0]);
        pv_next[0]     = fv_reg[FR_N-1];

        pt_next[1].pp[0] = ldcm_pkg::qm_pp(pt_reg[0].xn, pt_reg[0].xn);
        pt_next[1].pp[1] = ldcm_pkg::qm_pp(pt_reg[0].yn, pt_reg[0].yn);
        pt_next[1].pp[2] = ldcm_pkg::qm_pp(pt_reg[0].xn, pt_reg[0].yn);
        for (int k = 0; k < 3; k++)
        begin
            pt_next[2].sm[k] = ldcm_pkg::qm_sum(pt_reg[1].pp[k]);
        end
        pt_next[3].xx = ldcm_pkg::qm_sat(pt_reg[2].sm[0]);
        pt_next[3].yy = ldcm_pkg::qm_sat(pt_reg[2].sm[1]);
        pt_next[3].xy = ldcm_pkg::qm_sat(pt_reg[2].sm[2]);

        pt_next[4].r2  = ldcm_pkg::sadd(pt_reg[3].xx, pt_reg[3].yy);
        pt_next[4].xy2 = ldcm_pkg::sadd(pt_reg[3].xy, pt_reg[3].xy);
        pt_next[4].xx2 = ldcm_pkg::sadd(pt_reg[3].xx, pt_reg[3].xx);
        pt_next[4].yy2 = ldcm_pkg::sadd(pt_reg[3].yy, pt_reg[3].yy);
        pt_next[5].ax  = ldcm_pkg::sadd(pt_reg[4].r2, pt_reg[4].xx2);
        pt_next[5].ay  = ldcm_pkg::sadd(pt_reg[4].r2, pt_reg[4].yy2);

        pt_next[6].pp[0] = ldcm_pkg::qm_pp(pt_reg[5].r2, pt_reg[5].r2);
        pt_next[6].pp[1] = ldcm_pkg::qm_pp(k1, pt_reg[5].r2);
        pt_next[6].pp[2] = ldcm_pkg::qm_pp(p1, pt_reg[5].xy2);
        pt_next[6].pp[3] = ldcm_pkg::qm_pp(p2, pt_reg[5].ax);
        pt_next[6].pp[4] = ldcm_pkg::qm_pp(p1, pt_reg[5].ay);
        pt_next[6].pp[5] = ldcm_pkg::qm_pp(p2, pt_reg[5].xy2);
        for (int k = 0; k < 6; k++)
        begin
            pt_next[7].sm[k] = ldcm_pkg::qm_sum(pt_reg[6].pp[k]);
        end
        pt_next[8].r4   = ldcm_pkg::qm_sat(pt_reg[7].sm[0]);
        pt_next[8].k1r2 = ldcm_pkg::qm_sat(pt_reg[7].sm[1]);
        pt_next[8].t1   = ldcm_pkg::qm_sat(pt_reg[7].sm[2]);
        pt_next[8].t2   = ldcm_pkg::qm_sat(pt_reg[7].sm[3]);
        pt_next[8].t3   = ldcm_pkg::qm_sat(pt_reg[7].sm[4]);
        pt_next[8].t4   = ldcm_pkg::qm_sat(pt_reg[7].sm[5]);

        pt_next[9].tx    = ldcm_pkg::sadd(pt_reg[8].t1, pt_reg[8].t2);
        pt_next[9].ty    = ldcm_pkg::sadd(pt_reg[8].t3, pt_reg[8].t4);
        pt_next[9].pp[0] = ldcm_pkg::qm_pp(pt_reg[8].r4, pt_reg[8].r2);
        pt_next[9].pp[1] = ldcm_pkg::qm_pp(k2, pt_reg[8].r4);
        pt_next[10].sm[0] = ldcm_pkg::qm_sum(pt_reg[9].pp[0]);
        pt_next[10].sm[1] = ldcm_pkg::qm_sum(pt_reg[9].pp[1]);
        pt_next[11].r6   = ldcm_pkg::qm_sat(pt_reg[10].sm[0]);
        pt_next[11].k2r4 = ldcm_pkg::qm_sat(pt_reg[10].sm[1]);

        pt_next[12].pp[0] = ldcm_pkg::qm_pp(k3, pt_reg[11].r6);
        pt_next[13].sm[0] = ldcm_pkg::qm_sum(pt_reg[12].pp[0]);
        pt_next[14].k3r6  = ldcm_pkg::qm_sat(pt_reg[13].sm[0]);

        pt_next[15].radial = ldcm_pkg::sadd(
            ldcm_pkg::sadd(ldcm_pkg::ONE_Q24, pt_reg[14].k1r2),
            ldcm_pkg::sadd(pt_reg[14].k2r4, pt_reg[14].k3r6));

        pt_next[16].pp[0] = ldcm_pkg::qm_pp(pt_reg[15].radial, pt_reg[15].xn);
        pt_next[16].pp[1] = ldcm_pkg::qm_pp(pt_reg[15].radial, pt_reg[15].yn);
        pt_next[17].sm[0] = ldcm_pkg::qm_sum(pt_reg[16].pp[0]);
        pt_next[17].sm[1] = ldcm_pkg::qm_sum(pt_reg[16].pp[1]);
        pt_next[18].rx    = ldcm_pkg::qm_sat(pt_reg[17].sm[0]);
        pt_next[18].ry    = ldcm_pkg::qm_sat(pt_reg[17].sm[1]);
        pt_next[19].dxn   = ldcm_pkg::sadd(pt_reg[18].rx, pt_reg[18].tx);
        pt_next[19].dyn   = ldcm_pkg::sadd(pt_reg[18].ry, pt_reg[18].ty);

        // back to pixels with the same focal lengths
        pt_next[20].pp[0] = ldcm_pkg::qm_pp(ldcm_pkg::ux32(focal_reg[63:32]), pt_reg[19].dxn);
        pt_next[20].pp[1] = ldcm_pkg::qm_pp(ldcm_pkg::ux32(focal_reg[31:0]), pt_reg[19].dyn);
        pt_next[21].sm[0] = ldcm_pkg::qm_sum(pt_reg[20].pp[0]);
        pt_next[21].sm[1] = ldcm_pkg::qm_sum(pt_reg[20].pp[1]);
        pt_next[22].ux    = ldcm_pkg::qm_sat(pt_reg[21].sm[0]);
        pt_next[22].uy    = ldcm_pkg::qm_sat(pt_reg[21].sm[1]);
        pt_next[23].ox    = $signed(ldcm_pkg::to_q16(ldcm_pkg::sadd(pt_reg[22].ux,
                                ldcm_pkg::sx32(centre_reg[63:32]))));
        pt_next[23].oy    = $signed(ldcm_pkg::to_q16(ldcm_pkg::sadd(pt_reg[22].uy,
                                ldcm_pkg::sx32(centre_reg[31:0]))));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
            pv_reg <= '0;
        end
        else if (adv)
        begin
            fv_reg <= fv_next;
            pv_reg <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fr_reg <= fr_next;
            pt_reg <= pt_next;
        end
    end

    assign m_tvalid = pv_reg[PT_N-1];
    assign m_tdata  = {pt_reg[PT_N-1].oy, pt_reg[PT_N-1].ox,
                       pt_reg[PT_N-1].row, pt_reg[PT_N-1].col};

    `LDCM_ASSERT_IMPLY(a_col_in_frame, clk, rst_n, m_tvalid, {2'b00, m_tdata[11:0]} < w_clamp)
    `LDCM_ASSERT_IMPLY(a_row_in_frame, clk, rst_n, m_tvalid, {2'b00, m_tdata[23:12]} < h_clamp)
    `LDCM_ASSERT_NEXT(a_stall_freeze, clk, rst_n, !s_tready, $stable(fv_reg) && $stable(pv_reg))

endmodule

@@ tb/sv/lens_distortion_coordinate_map_checker.sv @@
module lens_distortion_coordinate_map_checker #(
    parameter int MAX_DIM = ldcm_pkg::MAX_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [63:0] CAP = 64'sh3FFF_FFFF_FFFF_FFFF;

    logic [63:0] focal, centre, tang, scale;
    logic [31:0] k1, k2, k3;
    logic [25:0] osize;
    logic [87:0] coord_queue[$];

    function automatic logic [63:0] magnitude(input logic signed [63:0] a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] clamp(input logic [63:0] m, input logic neg);
        logic signed [63:0] v;
        v = (m > 64'(CAP)) ? CAP : $signed(m);
        return neg ? -v : v;
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (s > CAP) return CAP;
        if (s < -CAP) return -CAP;
        return s;
    endfunction

    // q.24 product: exact 128-bit magnitude, truncated, saturated
    function automatic logic signed [63:0] mul_q24(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [127:0] p;
        logic         neg;
        neg = (a < 0) != (b < 0);
        p = 128'(magnitude(a)) * 128'(magnitude(b));
        if (p[127:88] != 0) return neg ? -CAP : CAP;
        return clamp(p[87:24], neg);
    endfunction

    function automatic logic signed [63:0] normalise(input logic signed [63:0] d,
                                                     input logic [31:0] f);
        logic [63:0] n;
        n = magnitude(d) << 15;
        if (n == 0) return 0;
        if (f == 0) return d < 0 ? -CAP : CAP;
        return clamp(n / 64'(f), d < 0);
    endfunction

    function automatic logic [31:0] fit_q16(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] sx(input logic [31:0] v);
        return 64'($signed(v));
    endfunction

    // returns 1 and the expected word when the pixel lies in the frame
    function automatic logic remap_pixel(input logic [11:0] col, input logic [11:0] row,
                                         output logic [87:0] word);
        logic [12:0] w, h;
        logic signed [63:0] cx, cy, xs, ys, xn, yn, xx, yy, xy, r2, r4, r6;
        logic signed [63:0] radial, xy2, tx, ty, dxn, dyn;
        logic [31:0] fx, fy;
        w = osize[12:0];
        h = osize[25:13];
        if (w > MAX_DIM) w = 13'(MAX_DIM);
        if (h > MAX_DIM) h = 13'(MAX_DIM);
        word = '0;
        if (col >= w || row >= h) return 1'b0;
        fx = focal[63:32];
        fy = focal[31:0];
        cx = sx(centre[63:32]);
        cy = sx(centre[31:0]);
        xs = $signed(64'(2 * 64'(col) + 1) * 64'(scale[63:32]));
        ys = $signed(64'(2 * 64'(row) + 1) * 64'(scale[31:0]));
        xn = normalise(xs - cx * 512, fx);
        yn = normalise(ys - cy * 512, fy);
        xx = mul_q24(xn, xn);
        yy = mul_q24(yn, yn);
        xy = mul_q24(xn, yn);
        r2 = add_sat(xx, yy);
        r4 = mul_q24(r2, r2);
        r6 = mul_q24(r4, r2);
        radial = add_sat(add_sat(64'sd16777216, mul_q24(sx(k1), r2)),
                         add_sat(mul_q24(sx(k2), r4), mul_q24(sx(k3), r6)));
        xy2 = add_sat(xy, xy);
        tx = add_sat(mul_q24(sx(tang[63:32]), xy2),
                     mul_q24(sx(tang[31:0]), add_sat(r2, add_sat(xx, xx))));
        ty = add_sat(mul_q24(sx(tang[63:32]), add_sat(r2, add_sat(yy, yy))),
                     mul_q24(sx(tang[31:0]), xy2));
        dxn = add_sat(mul_q24(radial, xn), tx);
        dyn = add_sat(mul_q24(radial, yn), ty);
        word = {fit_q16(add_sat(mul_q24($signed(64'(fy)), dyn), cy)),
                fit_q16(add_sat(mul_q24($signed(64'(fx)), dxn), cx)), row, col};
        return 1'b1;
    endfunction

    assign pending = coord_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [87:0] want;
        if (!rst_n)
        begin
            focal      <= 64'h0001_0000_0001_0000;
            centre     <= '0;
            k1         <= '0;
            k2         <= '0;
            k3         <= '0;
            tang       <= '0;
            scale      <= 64'h0100_0000_0100_0000;
            osize      <= '0;
            fail_count <= 0;
            coord_queue.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (coord_queue.size() == 0)
                begin
                    $error("unexpected word %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = coord_queue.pop_front();
                    if (want != m_tdata)
                    begin
                        fail_count <= fail_count + 1;
                        if (want[11:0] != m_tdata[11:0])
                            $error("dest_col expected %0d actual %0d", want[11:0], m_tdata[11:0]);
                        if (want[23:12] != m_tdata[23:12])
                            $error("dest_row expected %0d actual %0d",
                                   want[23:12], m_tdata[23:12]);
                        if (want[55:24] != m_tdata[55:24])
                            $error("source_x expected %0d actual %0d",
                                   $signed(want[55:24]), $signed(m_tdata[55:24]));
                        if (want[87:56] != m_tdata[87:56])
                            $error("source_y expected %0d actual %0d",
                                   $signed(want[87:56]), $signed(m_tdata[87:56]));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (remap_pixel(s_tdata[11:0], s_tdata[23:12], want))
                    coord_queue.push_back(want);
            end
            if (cfg_we)
            begin
                case (ldcm_pkg::cfg_idx_t'(cfg_addr))
                    ldcm_pkg::CFG_FOCAL:  focal  <= cfg_data;
                    ldcm_pkg::CFG_CENTRE: centre <= cfg_data;
                    ldcm_pkg::CFG_K1:     k1     <= cfg_data[31:0];
                    ldcm_pkg::CFG_K2:     k2     <= cfg_data[31:0];
                    ldcm_pkg::CFG_K3:     k3     <= cfg_data[31:0];
                    ldcm_pkg::CFG_TANG:   tang   <= cfg_data;
                    ldcm_pkg::CFG_SCALE:  scale  <= cfg_data;
                    ldcm_pkg::CFG_SIZE:   osize  <= cfg_data[25:0];
                    default:              ;
                endcase
            end
        end
    end

endmodule

@@ tb/sv/lens_distortion_coordinate_map_core_test.sv @@
module lens_distortion_coordinate_map_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [63:0] cfg_data = '0;
    logic        calm = 1'b0;
    int          fail_count;
    int          pending;

    lens_distortion_coordinate_map_core u_top (.*);

    lens_distortion_coordinate_map_checker u_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        int n;
        if (calm || $urandom_range(0, 3) != 0)
            m_tready <= 1'b1;
        else
        begin
            n = $urandom_range(1, 16);
            m_tready <= 1'b0;
            repeat (n) @(posedge clk);
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input ldcm_pkg::cfg_idx_t idx, input logic [63:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // ready is stable between rising edges, so it is looked at mid-cycle
    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col};
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic settle;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom(), $urandom()};
    endfunction

    // plausible lens: focal from 16 to just under 801 pixels, small coefficients
    task automatic lens_setting(input int w, input int h);
        write_reg(ldcm_pkg::CFG_FOCAL,
                  {32'($urandom_range(16, 800)) << 16 | $urandom_range(0, 65535),
                   32'($urandom_range(16, 800)) << 16 | $urandom_range(0, 65535)});
        write_reg(ldcm_pkg::CFG_CENTRE,
                  {32'($urandom_range(0, w)) << 16, 32'($urandom_range(0, h)) << 16});
        write_reg(ldcm_pkg::CFG_K1, 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23)));
        write_reg(ldcm_pkg::CFG_K2, 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)));
        write_reg(ldcm_pkg::CFG_K3, 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)));
        write_reg(ldcm_pkg::CFG_TANG, {32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                                       32'($signed($urandom_range(0, 1 << 18)) - (1 << 17))});
        write_reg(ldcm_pkg::CFG_SCALE, {32'($urandom_range(1 << 23, 1 << 25)),
                                        32'($urandom_range(1 << 23, 1 << 25))});
        write_reg(ldcm_pkg::CFG_SIZE, {13'(h), 13'(w)});
    endtask

    initial
    begin
        int w, h;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size is zero, so these are dropped
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        settle();

        // identity lens over an oversized frame, field extremes
        write_reg(ldcm_pkg::CFG_SIZE, {13'h1FFF, 13'h1FFF});
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        settle();

        // zero focal length, on and off the centre
        write_reg(ldcm_pkg::CFG_FOCAL, 64'd0);
        write_reg(ldcm_pkg::CFG_CENTRE, {32'h0000_8000, 32'h0000_8000});
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd5, 12'd0);
        send_pixel(12'd0, 12'd9);
        settle();

        // extreme coefficients and ratios, saturating throughout
        write_reg(ldcm_pkg::CFG_FOCAL, 64'hFFFF_FFFF_0000_0001);
        write_reg(ldcm_pkg::CFG_CENTRE, 64'h8000_0000_7FFF_FFFF);
        write_reg(ldcm_pkg::CFG_K1, 64'h7FFF_FFFF);
        write_reg(ldcm_pkg::CFG_K2, 64'h8000_0000);
        write_reg(ldcm_pkg::CFG_K3, 64'h7FFF_FFFF);
        write_reg(ldcm_pkg::CFG_TANG, 64'h8000_0000_7FFF_FFFF);
        write_reg(ldcm_pkg::CFG_SCALE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(ldcm_pkg::CFG_SIZE, {13'd4096, 13'd4096});
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'd1, 12'd1);
        settle();

        // frame edge: last column and row inside, next ones out
        write_reg(ldcm_pkg::CFG_SIZE, {13'd7, 13'd10});
        send_pixel(12'd9, 12'd6);
        send_pixel(12'd10, 12'd6);
        send_pixel(12'd9, 12'd7);
        settle();

        // random phases: mostly plausible lenses, some fully random registers
        for (int ph = 0; ph < 8; ph++)
        begin
            w = $urandom_range(1, 64);
            h = $urandom_range(1, 64);
            if (ph % 4 == 3)
            begin
                write_reg(ldcm_pkg::CFG_FOCAL, rand64());
                write_reg(ldcm_pkg::CFG_CENTRE, rand64());
                write_reg(ldcm_pkg::CFG_K1, rand64());
                write_reg(ldcm_pkg::CFG_K2, rand64());
                write_reg(ldcm_pkg::CFG_K3, rand64());
                write_reg(ldcm_pkg::CFG_TANG, rand64());
                write_reg(ldcm_pkg::CFG_SCALE, rand64());
                write_reg(ldcm_pkg::CFG_SIZE, {13'h1FFF, 13'h1FFF});
            end
            else
                lens_setting(w, h);
            calm = (ph == 7);
            for (int i = 0; i < 140; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_pixel(12'($urandom()), 12'($urandom()));
                else
                    send_pixel(12'($urandom_range(0, w - 1)), 12'($urandom_range(0, h - 1)));
            end
            settle();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule
